### hw/rtl/fsecrc_pkg.sv
// Shared types, constants and the CRC-16 step function for the frame encoder.
`default_nettype none
package fsecrc_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;
  localparam int unsigned QCW    = QAW + 1;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FLAG   = 2'd0,
    REG_ESCAPE = 2'd1,
    REG_MASK   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] flag_value;
    logic [7:0] escape_value;
    logic [7:0] stuff_mask;
  } cfg_t;

  // one classified message byte handed from front to back
  typedef struct packed {
    logic        open;
    logic [7:0]  data;
    logic        last;
    logic [15:0] crc;
  } cmd_t;

  // one-hot sequencer phases of the back end
  typedef enum logic [5:0] {
    ST_START = 6'b000001,
    ST_OPEN  = 6'b000010,
    ST_DATA  = 6'b000100,
    ST_CLO   = 6'b001000,
    ST_CHI   = 6'b010000,
    ST_CLOSE = 6'b100000
  } phase_t;

  // crc = T[crc>>8] ^ (crc<<8) ^ b, with T built bitwise from the polynomial
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = {crc[15:8], 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r ^ {crc[7:0], 8'h00} ^ {8'h00, b};
  endfunction

endpackage
`default_nettype wire

### hw/rtl/fsecrc_queue.sv
// Short command queue between the front and the back of the encoder.
`default_nettype none
module fsecrc_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire fsecrc_pkg::cmd_t push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output fsecrc_pkg::cmd_t     pop_data
);

  fsecrc_pkg::cmd_t                mem_r [fsecrc_pkg::QDEPTH];
  logic [fsecrc_pkg::QAW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [fsecrc_pkg::QAW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [fsecrc_pkg::QCW-1:0]      count_r, count_nxt;
  logic                            do_push, do_pop;

  assign push_ready = (count_r != fsecrc_pkg::QCW'(fsecrc_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/fsecrc_front.sv
// Front end: takes message bytes, tracks the open frame and the running CRC.
`default_nettype none
module fsecrc_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_data_byte,
  input  wire logic         in_last_byte,
  output logic              q_valid,
  input  wire logic         q_ready,
  output fsecrc_pkg::cmd_t  q_data
);

  logic [15:0] crc_r, crc_nxt;
  logic        open_r, open_nxt;
  logic [15:0] crc_upd;
  logic        accept;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign accept   = in_valid && q_ready;
  assign crc_upd  = fsecrc_pkg::crc_step(crc_r, in_data_byte);

  always_comb begin
    q_data.open = !open_r;
    q_data.data = in_data_byte;
    q_data.last = in_last_byte;
    q_data.crc  = crc_upd;
    crc_nxt     = crc_r;
    open_nxt    = open_r;
    if (accept) begin
      crc_nxt  = in_last_byte ? 16'h0000 : crc_upd;
      open_nxt = !in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= 16'h0000;
      open_r <= 1'b0;
    end else begin
      crc_r  <= crc_nxt;
      open_r <= open_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/fsecrc_back.sv
// Back end: expands each command into flag, stuffed bytes and trailer beats.
`default_nettype none
module fsecrc_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire fsecrc_pkg::cfg_t cfg,
  input  wire logic         q_valid,
  output logic              q_ready,
  input  wire fsecrc_pkg::cmd_t q_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [7:0]        out_byte,
  output logic              out_frame_end,
  output logic              out_run_last
);

  fsecrc_pkg::phase_t phase_r, phase_nxt, cur, phase_after;
  logic               esc_r, esc_nxt, esc_after;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         byte_r, byte_v;
  logic               end_r, end_v;
  logic               last_r, done;
  logic [7:0]         val;
  logic               needs;
  logic               load;

  assign load      = q_valid && (!out_valid_r || out_ready);
  assign q_ready   = load && done;
  assign out_valid = out_valid_r;
  assign out_byte  = byte_r;
  assign out_frame_end = end_r;
  assign out_run_last  = last_r;

  always_comb begin
    cur = phase_r;
    if (phase_r == fsecrc_pkg::ST_START) begin
      cur = q_data.open ? fsecrc_pkg::ST_OPEN : fsecrc_pkg::ST_DATA;
    end

    unique case (cur)
      fsecrc_pkg::ST_CLO: val = q_data.crc[7:0];
      fsecrc_pkg::ST_CHI: val = q_data.crc[15:8];
      default:            val = q_data.data;
    endcase
    needs = (val == cfg.flag_value) || (val == cfg.escape_value);

    byte_v      = val;
    end_v       = 1'b0;
    done        = 1'b0;
    phase_after = cur;
    esc_after   = 1'b0;

    unique case (cur) inside
      fsecrc_pkg::ST_OPEN: begin
        byte_v      = cfg.flag_value;
        phase_after = fsecrc_pkg::ST_DATA;
      end
      fsecrc_pkg::ST_DATA, fsecrc_pkg::ST_CLO, fsecrc_pkg::ST_CHI: begin
        if (needs && !esc_r) begin
          byte_v    = cfg.escape_value;
          esc_after = 1'b1;
        end else begin
          byte_v = esc_r ? (val ^ cfg.stuff_mask) : val;
          if (cur == fsecrc_pkg::ST_DATA) begin
            if (q_data.last) begin
              phase_after = fsecrc_pkg::ST_CLO;
            end else begin
              done = 1'b1;
            end
          end else if (cur == fsecrc_pkg::ST_CLO) begin
            phase_after = fsecrc_pkg::ST_CHI;
          end else begin
            phase_after = fsecrc_pkg::ST_CLOSE;
          end
        end
      end
      fsecrc_pkg::ST_CLOSE: begin
        byte_v = cfg.flag_value;
        end_v  = 1'b1;
        done   = 1'b1;
      end
      default: begin
        phase_after = fsecrc_pkg::ST_START;
      end
    endcase
    if (done) begin
      phase_after = fsecrc_pkg::ST_START;
    end

    phase_nxt     = load ? phase_after : phase_r;
    esc_nxt       = load ? esc_after : esc_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= fsecrc_pkg::ST_START;
      esc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      esc_r       <= esc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_v;
      end_r  <= end_v;
      last_r <= done;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/flag_stuffed_frame_encoder_crc16_unit.sv
// Top level of the flag-delimited, byte-stuffed frame encoder with CRC-16 trailer.
// Message bytes enter on the in_ channel (in_last_byte marks the final byte) and
// the framed stream leaves one byte per beat on the out_ channel. Input beats are
// queued (four entries); the back end emits one output beat per cycle while a
// command waits and out_ready is high, so one input byte yields 1 to 8 beats:
// one for the byte, one more if it is escaped, one for an opening flag, and for
// a last byte three to five more for the two stuffed CRC bytes and the closing
// flag. Sustained rate is set by the output sequencer at one beat per cycle while
// out_ready is high. The CRC (poly 0x1021, start 0x0000) covers raw bytes only;
// the low byte goes first. out_frame_end marks the closing flag, out_run_last the
// final beat caused by an input byte. Write configuration only while idle.
`default_nettype none
module flag_stuffed_frame_encoder_crc16_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_frame_end,
  output logic            out_run_last,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  fsecrc_pkg::cfg_t cfg_r, cfg_nxt;
  fsecrc_pkg::cmd_t push_data, pop_data;
  logic             push_valid, push_ready, pop_valid, pop_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        fsecrc_pkg::REG_FLAG:   cfg_nxt.flag_value   = cfg_wdata;
        fsecrc_pkg::REG_ESCAPE: cfg_nxt.escape_value = cfg_wdata;
        fsecrc_pkg::REG_MASK:   cfg_nxt.stuff_mask   = cfg_wdata;
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_value   <= 8'h7E;
      cfg_r.escape_value <= 8'h7D;
      cfg_r.stuff_mask   <= 8'h20;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fsecrc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_valid      (push_valid),
    .q_ready      (push_ready),
    .q_data       (push_data)
  );

  fsecrc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  fsecrc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (pop_valid),
    .q_ready       (pop_ready),
    .q_data        (pop_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .out_run_last  (out_run_last)
  );

endmodule
`default_nettype wire
